>>> rtl/tcwiir_pkg.sv
// Shared constants, types and a helper function for the three-channel window IIR filter.
// Has no dependencies; every other file in the folder but tcwiir_ram imports it.
package tcwiir_pkg;

  localparam int SAMPLE_BITS      = 12;
  localparam int NUM_LANES        = 3;
  localparam int SAMPLES_PER_LANE = 4;
  localparam int AVG_SHIFT        = 2;
  localparam int SMOOTH_SHIFT     = 3;
  localparam int WINDOW_LOG2      = 6;
  localparam int WINDOW_DEPTH     = 1 << WINDOW_LOG2;
  localparam int SUM_BITS         = SAMPLE_BITS + WINDOW_LOG2;
  localparam int ACC_BITS         = SAMPLE_BITS + $clog2(SAMPLES_PER_LANE);
  localparam int RAM_WIDTH        = NUM_LANES * SAMPLE_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [WINDOW_LOG2-1:0] slot_t;
  typedef logic [RAM_WIDTH-1:0]   row_t;

  // Sum of four samples, shifted right with truncation.
  function automatic sample_t lane_average(input sample_t s0, input sample_t s1,
                                           input sample_t s2, input sample_t s3);
    logic [ACC_BITS-1:0] acc;
    acc = ACC_BITS'(s0) + ACC_BITS'(s1) + ACC_BITS'(s2) + ACC_BITS'(s3);
    return acc[AVG_SHIFT +: SAMPLE_BITS];
  endfunction

endpackage

>>> rtl/tcwiir_in_if.sv
// Input channel of the filter: valid/ready handshake and twelve converter samples.
// Depends on tcwiir_pkg for the sample type.
interface tcwiir_in_if;
  import tcwiir_pkg::*;

  logic    valid;
  logic    ready;
  sample_t az_s0, az_s1, az_s2, az_s3;
  sample_t x_s0, x_s1, x_s2, x_s3;
  sample_t y_s0, y_s1, y_s2, y_s3;

  modport source (
    output valid, az_s0, az_s1, az_s2, az_s3, x_s0, x_s1, x_s2, x_s3,
           y_s0, y_s1, y_s2, y_s3,
    input  ready
  );
  modport sink (
    input  valid, az_s0, az_s1, az_s2, az_s3, x_s0, x_s1, x_s2, x_s3,
           y_s0, y_s1, y_s2, y_s3,
    output ready
  );
endinterface

>>> rtl/tcwiir_out_if.sv
// Output channel of the filter: valid/ready handshake, smoothed values and change flags.
// Depends on tcwiir_pkg for the sample type.
interface tcwiir_out_if;
  import tcwiir_pkg::*;

  logic    valid;
  logic    ready;
  sample_t smooth_az, smooth_x, smooth_y;
  logic    changed_az, changed_x, changed_y;

  modport source (
    output valid, smooth_az, smooth_x, smooth_y, changed_az, changed_x, changed_y,
    input  ready
  );
  modport sink (
    input  valid, smooth_az, smooth_x, smooth_y, changed_az, changed_x, changed_y,
    output ready
  );
endinterface

>>> rtl/tcwiir_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; no package dependencies.
module tcwiir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tcwiir_lane.sv
// Per-channel update: running window sum, window mean and the 7/8 + 1/8 smoother.
// Depends on tcwiir_pkg for widths and types.
module tcwiir_lane (
  input  tcwiir_pkg::sample_t value_i,
  input  tcwiir_pkg::sample_t oldest_i,
  input  tcwiir_pkg::sum_t    sum_i,
  input  tcwiir_pkg::sample_t prev_i,
  output tcwiir_pkg::sum_t    sum_o,
  output tcwiir_pkg::sample_t smooth_o,
  output logic                changed_o
);
  import tcwiir_pkg::*;

  sum_t    sum_new;
  sample_t mean;
  sample_t smooth;

  always_comb begin
    sum_new = sum_i + SUM_BITS'(value_i) - SUM_BITS'(oldest_i);
    mean    = sum_new[WINDOW_LOG2 +: SAMPLE_BITS];
    smooth  = prev_i - (prev_i >> SMOOTH_SHIFT) + (mean >> SMOOTH_SHIFT);
  end

  assign sum_o     = sum_new;
  assign smooth_o  = smooth;
  assign changed_o = (smooth != prev_i);

endmodule

>>> rtl/three_channel_window_iir_filter_core.sv
// Timing: the window memory is read and the lane averages are registered at the accepting edge;
// the sum update, smoothing, write-back and the result register follow when that stage fires.
// Throughput: one transaction per cycle while the output is not back-pressured; the read of the next slot
// overlaps the write of the current one in the window memory. Reset: rst_ni clears the running sums, the
// smoother state, the ring position and the window valid bits, so the window reads as zero.
module three_channel_window_iir_filter_core (
  input logic         clk_i,
  input logic         rst_ni,
  tcwiir_in_if.sink   in_i,
  tcwiir_out_if.source out_o
);
  import tcwiir_pkg::*;

  sample_t                 avg       [NUM_LANES];
  sample_t                 oldest    [NUM_LANES];
  sum_t                    sum_next  [NUM_LANES];
  sample_t                 smooth_nx [NUM_LANES];
  logic [NUM_LANES-1:0]    changed_nx;
  row_t                    wr_row;
  row_t                    rd_row;

  slot_t                   slot_q;
  logic [WINDOW_DEPTH-1:0] filled_q;
  logic                    s1_valid_q;
  sample_t                 s1_avg_q  [NUM_LANES];
  slot_t                   s1_slot_q;
  logic                    s1_filled_q;
  sum_t                    sums_q    [NUM_LANES];
  sample_t                 prev_q    [NUM_LANES];
  logic                    out_valid_q;
  sample_t                 smooth_q  [NUM_LANES];
  logic [NUM_LANES-1:0]    changed_q;

  logic accept;
  logic s1_fire;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign accept     = in_i.valid && in_i.ready;

  assign avg[0] = lane_average(in_i.az_s0, in_i.az_s1, in_i.az_s2, in_i.az_s3);
  assign avg[1] = lane_average(in_i.x_s0, in_i.x_s1, in_i.x_s2, in_i.x_s3);
  assign avg[2] = lane_average(in_i.y_s0, in_i.y_s1, in_i.y_s2, in_i.y_s3);

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      wr_row[l*SAMPLE_BITS +: SAMPLE_BITS] = s1_avg_q[l];
      oldest[l] = s1_filled_q ? rd_row[l*SAMPLE_BITS +: SAMPLE_BITS] : '0;
    end
  end

  tcwiir_ram #(
    .WIDTH(RAM_WIDTH),
    .DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (s1_fire),
    .waddr_i(s1_slot_q),
    .wdata_i(wr_row),
    .re_i   (accept),
    .raddr_i(slot_q),
    .rdata_o(rd_row)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : gen_lane
    tcwiir_lane u_lane (
      .value_i  (s1_avg_q[g]),
      .oldest_i (oldest[g]),
      .sum_i    (sums_q[g]),
      .prev_i   (prev_q[g]),
      .sum_o    (sum_next[g]),
      .smooth_o (smooth_nx[g]),
      .changed_o(changed_nx[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      filled_q    <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < NUM_LANES; l++) begin
        sums_q[l] <= '0;
        prev_q[l] <= '0;
      end
    end else begin
      if (accept) begin
        slot_q <= slot_q + 1'b1;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        filled_q[s1_slot_q] <= 1'b1;
        for (int l = 0; l < NUM_LANES; l++) begin
          sums_q[l] <= sum_next[l];
          prev_q[l] <= smooth_nx[l];
        end
      end
      if (s1_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_slot_q   <= slot_q;
      s1_filled_q <= filled_q[slot_q];
      for (int l = 0; l < NUM_LANES; l++) begin
        s1_avg_q[l] <= avg[l];
      end
    end
    if (s1_fire) begin
      changed_q <= changed_nx;
      for (int l = 0; l < NUM_LANES; l++) begin
        smooth_q[l] <= smooth_nx[l];
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.smooth_az  = smooth_q[0];
  assign out_o.smooth_x   = smooth_q[1];
  assign out_o.smooth_y   = smooth_q[2];
  assign out_o.changed_az = changed_q[0];
  assign out_o.changed_x  = changed_q[1];
  assign out_o.changed_y  = changed_q[2];

endmodule

>>> tb/tb_three_channel_window_iir_filter_core.sv
// Self-checking testbench for three_channel_window_iir_filter_core: directed rows, then random
// segments, checked against a window mean and 1/8 smoother predictor, or typed values for two rows.
// Depends on tcwiir_pkg, tcwiir_in_if, tcwiir_out_if and the core RTL.
`timescale 1ns / 100ps

module tb_three_channel_window_iir_filter_core;
  import tcwiir_pkg::*;

  localparam int LANE_AZ       = 0;
  localparam int LANE_X        = 1;
  localparam int LANE_Y        = 2;
  localparam int DIRECTED_ROWS = 22;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;

  typedef logic [SAMPLES_PER_LANE*SAMPLE_BITS-1:0] lane_word_t;
  typedef sample_t [NUM_LANES-1:0][SAMPLES_PER_LANE-1:0] sample_set_t;

  typedef struct packed {
    sample_t smooth_az;
    sample_t smooth_x;
    sample_t smooth_y;
    logic    changed_az;
    logic    changed_x;
    logic    changed_y;
  } filt_result_t;

  typedef struct packed {
    sample_set_t  stim;
    logic         typed;
    filt_result_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  tcwiir_in_if  in_if ();
  tcwiir_out_if out_if ();

  three_channel_window_iir_filter_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sample_t      win_hist    [NUM_LANES][WINDOW_DEPTH];
  sum_t         lane_sum    [NUM_LANES];
  slot_t        ring_pos;
  sample_t      last_smooth [NUM_LANES];

  filt_result_t filt_expected [$];
  stim_row_t    directed_rows [DIRECTED_ROWS];

  int error_count    = 0;
  int cycle_count    = 0;
  int results_seen   = 0;
  int steady_results = 0;
  int directed_sent  = 0;
  int random_sent    = 0;
  int drain_pauses   = 0;
  int burst_left     = 0;
  int stall_mode     = 0;
  int stall_left     = 0;

  function automatic filt_result_t smooth_step(input sample_set_t set);
    filt_result_t        res;
    logic [ACC_BITS-1:0] acc;
    sample_t             avg;
    sample_t             mean;
    sample_t             nxt;
    sample_t             smooth  [NUM_LANES];
    logic                changed [NUM_LANES];
    for (int l = 0; l < NUM_LANES; l++) begin
      acc = '0;
      for (int k = 0; k < SAMPLES_PER_LANE; k++) acc = acc + ACC_BITS'(set[l][k]);
      avg = sample_t'(acc >> AVG_SHIFT);
      lane_sum[l] = lane_sum[l] + sum_t'(avg) - sum_t'(win_hist[l][ring_pos]);
      win_hist[l][ring_pos] = avg;
      mean = sample_t'(lane_sum[l] >> WINDOW_LOG2);
      nxt = last_smooth[l] - (last_smooth[l] >> SMOOTH_SHIFT) + (mean >> SMOOTH_SHIFT);
      smooth[l] = nxt;
      changed[l] = (nxt != last_smooth[l]);
      last_smooth[l] = nxt;
    end
    ring_pos = ring_pos + 1'b1;
    res.smooth_az  = smooth[LANE_AZ];
    res.smooth_x   = smooth[LANE_X];
    res.smooth_y   = smooth[LANE_Y];
    res.changed_az = changed[LANE_AZ];
    res.changed_x  = changed[LANE_X];
    res.changed_y  = changed[LANE_Y];
    return res;
  endfunction

  function automatic stim_row_t mk_row(input lane_word_t az, input lane_word_t x,
                                       input lane_word_t y, input logic typed,
                                       input filt_result_t res);
    stim_row_t row;
    row.stim[LANE_AZ] = az;
    row.stim[LANE_X]  = x;
    row.stim[LANE_Y]  = y;
    row.typed         = typed;
    row.res           = res;
    return row;
  endfunction

  task automatic drive_payload(input sample_set_t set);
    in_if.az_s0 <= set[LANE_AZ][0];
    in_if.az_s1 <= set[LANE_AZ][1];
    in_if.az_s2 <= set[LANE_AZ][2];
    in_if.az_s3 <= set[LANE_AZ][3];
    in_if.x_s0  <= set[LANE_X][0];
    in_if.x_s1  <= set[LANE_X][1];
    in_if.x_s2  <= set[LANE_X][2];
    in_if.x_s3  <= set[LANE_X][3];
    in_if.y_s0  <= set[LANE_Y][0];
    in_if.y_s1  <= set[LANE_Y][1];
    in_if.y_s2  <= set[LANE_Y][2];
    in_if.y_s3  <= set[LANE_Y][3];
  endtask

  // Called right after a rising edge; returns right after the edge that accepted the transaction.
  task automatic send_item(input sample_set_t set, input logic typed,
                           input filt_result_t typed_res);
    filt_result_t predicted;
    if (burst_left == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid <= 1'b1;
    drive_payload(set);
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = smooth_step(set);
    filt_expected.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_pause();
    in_if.valid <= 1'b0;
    while (filt_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    drain_pauses++;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    filt_result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (filt_expected.size() == 0) begin
        $error("Result transaction arrived with no expectation pending");
        error_count++;
      end else begin
        exp_r = filt_expected.pop_front();
        check_field("smooth_az", int'(exp_r.smooth_az), int'(out_if.smooth_az));
        check_field("smooth_x", int'(exp_r.smooth_x), int'(out_if.smooth_x));
        check_field("smooth_y", int'(exp_r.smooth_y), int'(out_if.smooth_y));
        check_field("changed_az", int'(exp_r.changed_az), int'(out_if.changed_az));
        check_field("changed_x", int'(exp_r.changed_x), int'(out_if.changed_x));
        check_field("changed_y", int'(exp_r.changed_y), int'(out_if.changed_y));
        results_seen++;
        if (!out_if.changed_az && !out_if.changed_x && !out_if.changed_y) steady_results++;
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0:       out_if.ready <= 1'b1;
      1:       out_if.ready <= 1'($urandom_range(0, 1));
      2:       out_if.ready <= ($urandom_range(0, 7) != 0);
      default: out_if.ready <= (cycle_count[2:0] != 3'd5) && (cycle_count[2:0] != 3'd6);
    endcase
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $error("Run exceeded %0d cycles", CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    sample_set_t set;
    sample_t     level  [NUM_LANES];
    sample_t     jitter [NUM_LANES];
    int          seg_kind;
    int          seg_len;
    int          pick;

    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    drive_payload('0);
    for (int l = 0; l < NUM_LANES; l++) begin
      lane_sum[l]    = '0;
      last_smooth[l] = '0;
      for (int d = 0; d < WINDOW_DEPTH; d++) win_hist[l][d] = '0;
    end
    ring_pos = '0;

    directed_rows[0] = mk_row('0, '0, '0, 1'b1, '{12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0});
    directed_rows[1] = mk_row({4{12'hFFF}}, {4{12'hFFF}}, {4{12'hFFF}}, 1'b1,
                              '{12'd7, 12'd7, 12'd7, 1'b1, 1'b1, 1'b1});
    directed_rows[2] = mk_row({12'hFFF, 12'h000, 12'h000, 12'h000},
                              {12'h000, 12'h000, 12'h000, 12'hFFF},
                              {12'h000, 12'hFFF, 12'h000, 12'h000}, 1'b0, '0);
    directed_rows[3] = mk_row({12'h000, 12'h000, 12'h000, 12'h003},
                              {12'h000, 12'h001, 12'h001, 12'h001},
                              {12'h003, 12'h000, 12'h000, 12'h000}, 1'b0, '0);
    directed_rows[4] = mk_row({12'h001, 12'h001, 12'h001, 12'h001},
                              {12'h002, 12'h002, 12'h002, 12'h001},
                              {12'h000, 12'h000, 12'h000, 12'h004}, 1'b0, '0);
    directed_rows[5] = mk_row({4{12'hAAA}}, {4{12'hAAA}}, {4{12'hAAA}}, 1'b0, '0);
    directed_rows[6] = mk_row({4{12'h555}}, {4{12'h555}}, {4{12'h555}}, 1'b0, '0);
    directed_rows[7] = mk_row({12'h800, 12'h400, 12'h200, 12'h100},
                              {12'h080, 12'h040, 12'h020, 12'h010},
                              {12'h008, 12'h004, 12'h002, 12'h001}, 1'b0, '0);
    directed_rows[8] = mk_row({4{12'hFFF}}, {4{12'h000}}, {4{12'h7FF}}, 1'b0, '0);
    directed_rows[9] = mk_row({4{12'h000}}, {4{12'hFFF}}, {4{12'h800}}, 1'b0, '0);
    for (int r = 10; r < DIRECTED_ROWS; r++)
      directed_rows[r] = mk_row({4{12'hFFF}}, {4{12'hFFF}}, {4{12'hFFF}}, 1'b0, '0);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].res);
      directed_sent++;
    end
    drain_pause();

    while (random_sent < RANDOM_ITEMS) begin
      seg_kind = $urandom_range(0, 9);
      seg_len  = (seg_kind < 5) ? $urandom_range(100, 300) : $urandom_range(20, 80);
      for (int l = 0; l < NUM_LANES; l++) begin
        pick = $urandom_range(0, 2);
        level[l]  = (pick == 0) ? 12'h000 : (pick == 1) ? 12'hFFF : sample_t'($urandom);
        pick = $urandom_range(0, 2);
        jitter[l] = (pick == 0) ? 12'h000 : (pick == 1) ? 12'h003 : 12'h03F;
      end
      for (int n = 0; n < seg_len; n++) begin
        for (int l = 0; l < NUM_LANES; l++)
          for (int k = 0; k < SAMPLES_PER_LANE; k++)
            if (seg_kind < 5)
              set[l][k] = level[l] ^ (sample_t'($urandom) & jitter[l]);
            else if (seg_kind < 8)
              set[l][k] = sample_t'($urandom);
            else
              set[l][k] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
        send_item(set, 1'b0, '0);
        random_sent++;
      end
      if ($urandom_range(0, 3) == 0) drain_pause();
    end

    in_if.valid <= 1'b0;
    while (filt_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (filt_expected.size() != 0) begin
      $error("%0d expected results never arrived", filt_expected.size());
      error_count++;
    end
    $display("Sent %0d directed and %0d random transactions with %0d full drains.",
             directed_sent, random_sent, drain_pauses);
    $display("Checked %0d results, %0d of them with all three channels settled.",
             results_seen, steady_results);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> three_channel_window_iir_filter_core.f
rtl/tcwiir_pkg.sv
rtl/tcwiir_in_if.sv
rtl/tcwiir_out_if.sv
rtl/tcwiir_ram.sv
rtl/tcwiir_lane.sv
rtl/three_channel_window_iir_filter_core.sv
tb/tb_three_channel_window_iir_filter_core.sv
